>>> hdl/pfde_pkg.sv
`timescale 1ns / 1ps

package pfde_pkg;

    typedef logic signed [12:0] coord_t;
    typedef logic signed [15:0] err_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LINE_SETUP,
        ST_TEST,
        ST_WRITE,
        ST_RDBYTE,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        KIND_H,
        KIND_V,
        KIND_WIDE,
        KIND_TALL
    } kind_t;

    localparam logic [2:0] CMD_PIXEL = 3'd0;
    localparam logic [2:0] CMD_LINE  = 3'd1;
    localparam logic [2:0] CMD_BOX   = 3'd2;
    localparam logic [2:0] CMD_FILL  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [1:0] COLOR_BLACK  = 2'd0;
    localparam logic [1:0] COLOR_WHITE  = 2'd1;
    localparam logic [1:0] COLOR_TOGGLE = 2'd2;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [1:0] SEG_LAST = 2'd3;

    localparam logic [2:0] PIX_BIT_MASK = 3'h7;

endpackage

>>> hdl/pfde_fb_ram.sv
`timescale 1ns / 1ps

module pfde_fb_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/page_framebuffer_draw_engine_top.sv
`timescale 1ns / 1ps
// channel  | ports                                  | contents
// s_       | s_tvalid s_tready s_tdata s_tuser      | one drawing or read command
// m_       | m_tvalid m_tready m_tdata              | read_data, one beat per command
// cfg_     | cfg_valid cfg_ready cfg_index cfg_data | display_width, display_height
// A drawn pixel is read, then written back, in its frame store byte (TEST, then
// WRITE); a skipped one is only tested. Each run or box row adds setup and exit
// states, and a command ends in DONE, which hands off the result. A read command
// passes DECODE, then RDBYTE if its address is on screen, then DONE.
// After reset a clearing pass zeroes all MAX_COLUMNS*MAX_PAGES store bytes;
// s_tready stays low meanwhile. A stalled result holds the next command's finish.

module page_framebuffer_draw_engine_top #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_PAGES   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_x[11:0] start_y[23:12] end_x[35:24] end_y[47:36] color[49:48]
    // read_column[57:50] read_page[60:58]
    input  logic [63:0] s_tdata,
    // command[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0]
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int DEPTH = MAX_COLUMNS * MAX_PAGES;
    localparam int AW    = $clog2(DEPTH);

    pfde_pkg::state_t state_reg, state_next;
    pfde_pkg::kind_t  kind_reg, kind_next;

    logic [8:0]  dw_reg;
    logic [6:0]  dh_reg;
    logic [AW-1:0] clr_reg, clr_next;

    logic [2:0]  cmd_reg;
    pfde_pkg::coord_t x0_reg, y0_reg, x1_reg, y1_reg;
    logic [1:0]  color_reg;
    logic [7:0]  col_reg;
    logic [2:0]  page_reg;

    logic [1:0]  seg_reg, seg_next;
    pfde_pkg::coord_t row_reg, row_next;
    pfde_pkg::coord_t cx_reg, cx_next, cy_reg, cy_next, lim_reg, lim_next;
    pfde_pkg::err_t err_reg, err_next, dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic        neg_reg, neg_next;
    pfde_pkg::coord_t adx_reg, adx_next, ady_reg, ady_next;
    logic [AW-1:0] addr_reg;
    logic [7:0]  mask_reg;
    logic [7:0]  res_reg, res_next;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;

    logic [8:0]  w_eff;
    logic [6:0]  h_eff;
    pfde_pkg::coord_t w_s, h_s;

    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;

    logic        vis, go;
    logic [13:0] pix_addr, rd_addr;
    logic        rd_ok;
    pfde_pkg::coord_t hx, hy, hxe, vx, vlim;
    pfde_pkg::coord_t dxs, dys;
    logic        wide, swp;
    pfde_pkg::coord_t adv_cx, adv_cy;
    pfde_pkg::err_t adv_err;

    assign w_eff = (dw_reg > 9'(MAX_COLUMNS)) && (MAX_COLUMNS < 512) ? 9'(MAX_COLUMNS) : dw_reg;
    assign h_eff = (32'(dh_reg) > MAX_PAGES * 8) ? 7'(MAX_PAGES * 8) : dh_reg;
    assign w_s   = $signed({4'b0, w_eff});
    assign h_s   = $signed({6'b0, h_eff});

    assign vis = (cx_reg >= 0) && (cx_reg < w_s) && (cy_reg >= 0) && (cy_reg < h_s);
    assign pix_addr = 14'(cy_reg[6:3]) * 14'(w_eff) + 14'(cx_reg[8:0]);
    assign rd_addr  = 14'(page_reg) * 14'(w_eff) + 14'(col_reg);
    assign rd_ok    = ({1'b0, col_reg} < w_eff) && (32'(page_reg) < MAX_PAGES);

    always_comb begin
        case (kind_reg)
            pfde_pkg::KIND_H:    go = cx_reg < lim_reg;
            pfde_pkg::KIND_V:    go = (cy_reg < lim_reg) && vis;
            pfde_pkg::KIND_WIDE: go = cx_reg < lim_reg;
            default:             go = cy_reg < lim_reg;
        endcase
    end

    always_comb begin
        adv_cx  = cx_reg;
        adv_cy  = cy_reg;
        adv_err = err_reg;
        case (kind_reg)
            pfde_pkg::KIND_H: adv_cx = cx_reg + 13'sd1;
            pfde_pkg::KIND_V: adv_cy = cy_reg + 13'sd1;
            pfde_pkg::KIND_WIDE: begin
                adv_cx = cx_reg + 13'sd1;
                if (err_reg > 0) begin
                    adv_cy  = neg_reg ? cy_reg - 13'sd1 : cy_reg + 13'sd1;
                    adv_err = err_reg + dy2_reg - dx2_reg;
                end else begin
                    adv_err = err_reg + dy2_reg;
                end
            end
            default: begin
                adv_cy = cy_reg + 13'sd1;
                if (err_reg > 0) begin
                    adv_cx  = neg_reg ? cx_reg - 13'sd1 : cx_reg + 13'sd1;
                    adv_err = err_reg + dx2_reg - dy2_reg;
                end else begin
                    adv_err = err_reg + dx2_reg;
                end
            end
        endcase
    end

    always_comb begin
        case (seg_reg)
            2'd0:    hy = y0_reg;
            2'd1:    hy = y1_reg;
            default: hy = y0_reg;
        endcase
        if (cmd_reg == pfde_pkg::CMD_FILL) begin
            hy = row_reg;
        end
        hx  = (x0_reg < 0) ? 13'sd0 : x0_reg;
        hxe = (x1_reg >= w_s) ? w_s - 13'sd1 : x1_reg;
        if (hy < 0) begin
            hy = 13'sd0;
        end else if (hy >= h_s) begin
            hy = h_s - 13'sd1;
        end
        vx   = (seg_reg == pfde_pkg::SEG_LAST) ? x1_reg : x0_reg;
        vlim = (cmd_reg == pfde_pkg::CMD_PIXEL) ? y0_reg + 13'sd1 : y1_reg;
        dxs  = x1_reg - x0_reg;
        dys  = y1_reg - y0_reg;
        wide = adx_reg > ady_reg;
        swp  = wide ? (x0_reg > x1_reg) : (y0_reg > y1_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfde_pkg::ST_CLEAR: begin
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = pfde_pkg::ST_IDLE;
                end
            end
            pfde_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = pfde_pkg::ST_DECODE;
                end
            end
            pfde_pkg::ST_DECODE: begin
                case (cmd_reg)
                    pfde_pkg::CMD_PIXEL: state_next = pfde_pkg::ST_TEST;
                    pfde_pkg::CMD_LINE: begin
                        if (x0_reg == x1_reg) begin
                            state_next = pfde_pkg::ST_TEST;
                        end else if (y0_reg == y1_reg) begin
                            state_next = (h_eff == 7'd0) ? pfde_pkg::ST_NEXT
                                                         : pfde_pkg::ST_TEST;
                        end else begin
                            state_next = pfde_pkg::ST_LINE_SETUP;
                        end
                    end
                    pfde_pkg::CMD_BOX: begin
                        if (seg_reg[1] || (h_eff != 7'd0)) begin
                            state_next = pfde_pkg::ST_TEST;
                        end else begin
                            state_next = pfde_pkg::ST_NEXT;
                        end
                    end
                    pfde_pkg::CMD_FILL: begin
                        if (row_reg > y1_reg) begin
                            state_next = pfde_pkg::ST_DONE;
                        end else if (h_eff == 7'd0) begin
                            state_next = pfde_pkg::ST_NEXT;
                        end else begin
                            state_next = pfde_pkg::ST_TEST;
                        end
                    end
                    pfde_pkg::CMD_READ: begin
                        state_next = rd_ok ? pfde_pkg::ST_RDBYTE : pfde_pkg::ST_DONE;
                    end
                    default: state_next = pfde_pkg::ST_DONE;
                endcase
            end
            pfde_pkg::ST_LINE_SETUP: state_next = pfde_pkg::ST_TEST;
            pfde_pkg::ST_TEST: begin
                if (!go) begin
                    state_next = pfde_pkg::ST_NEXT;
                end else if (vis) begin
                    state_next = pfde_pkg::ST_WRITE;
                end
            end
            pfde_pkg::ST_WRITE:  state_next = pfde_pkg::ST_TEST;
            pfde_pkg::ST_RDBYTE: state_next = pfde_pkg::ST_DONE;
            pfde_pkg::ST_NEXT: begin
                if ((cmd_reg == pfde_pkg::CMD_BOX && seg_reg != pfde_pkg::SEG_LAST)
                    || cmd_reg == pfde_pkg::CMD_FILL) begin
                    state_next = pfde_pkg::ST_DECODE;
                end else begin
                    state_next = pfde_pkg::ST_DONE;
                end
            end
            pfde_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = pfde_pkg::ST_IDLE;
                end
            end
            default: state_next = pfde_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        clr_next  = clr_reg;
        kind_next = kind_reg;
        seg_next  = seg_reg;
        row_next  = row_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        lim_next  = lim_reg;
        err_next  = err_reg;
        dx2_next  = dx2_reg;
        dy2_next  = dy2_reg;
        neg_next  = neg_reg;
        adx_next  = adx_reg;
        ady_next  = ady_reg;
        res_next  = res_reg;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = ram_rdata & ~mask_reg;
        ram_raddr = AW'(pix_addr);
        case (color_reg)
            pfde_pkg::COLOR_TOGGLE: ram_wdata = ram_rdata ^ mask_reg;
            pfde_pkg::COLOR_WHITE:  ram_wdata = ram_rdata | mask_reg;
            default:                ram_wdata = ram_rdata & ~mask_reg;
        endcase
        case (state_reg)
            pfde_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'd0;
                clr_next  = clr_reg + AW'(1);
            end
            pfde_pkg::ST_IDLE: begin
                seg_next = 2'd0;
                res_next = 8'd0;
                row_next = {s_tdata[23], s_tdata[23:12]};
            end
            pfde_pkg::ST_DECODE: begin
                ram_raddr = AW'(rd_addr);
                if ((cmd_reg == pfde_pkg::CMD_LINE && x0_reg == x1_reg)
                    || cmd_reg == pfde_pkg::CMD_PIXEL
                    || (cmd_reg == pfde_pkg::CMD_BOX && seg_reg[1])) begin
                    kind_next = pfde_pkg::KIND_V;
                    cx_next   = vx;
                    cy_next   = y0_reg;
                    lim_next  = vlim;
                end else begin
                    kind_next = pfde_pkg::KIND_H;
                    cx_next   = hx;
                    cy_next   = hy;
                    lim_next  = hxe;
                end
                adx_next = (dxs < 0) ? -dxs : dxs;
                ady_next = (dys < 0) ? -dys : dys;
            end
            pfde_pkg::ST_LINE_SETUP: begin
                if (wide) begin
                    kind_next = pfde_pkg::KIND_WIDE;
                    cx_next   = swp ? x1_reg : x0_reg;
                    cy_next   = swp ? y1_reg : y0_reg;
                    lim_next  = swp ? x0_reg : x1_reg;
                    neg_next  = (y1_reg < y0_reg) ^ swp;
                    err_next  = (16'(ady_reg) <<< 1) - 16'(adx_reg);
                end else begin
                    kind_next = pfde_pkg::KIND_TALL;
                    cx_next   = swp ? x1_reg : x0_reg;
                    cy_next   = swp ? y1_reg : y0_reg;
                    lim_next  = swp ? y0_reg : y1_reg;
                    neg_next  = (x1_reg < x0_reg) ^ swp;
                    err_next  = (16'(adx_reg) <<< 1) - 16'(ady_reg);
                end
                dx2_next = 16'(adx_reg) <<< 1;
                dy2_next = 16'(ady_reg) <<< 1;
            end
            pfde_pkg::ST_TEST: begin
                if (go && !vis) begin
                    cx_next  = adv_cx;
                    cy_next  = adv_cy;
                    err_next = adv_err;
                end
            end
            pfde_pkg::ST_WRITE: begin
                ram_we   = 1'b1;
                cx_next  = adv_cx;
                cy_next  = adv_cy;
                err_next = adv_err;
            end
            pfde_pkg::ST_RDBYTE: begin
                res_next = ram_rdata;
            end
            pfde_pkg::ST_NEXT: begin
                seg_next = seg_reg + 2'd1;
                row_next = row_reg + 13'sd1;
            end
            default: begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pfde_pkg::ST_CLEAR;
            clr_reg      <= '0;
            dw_reg       <= 9'd128;
            dh_reg       <= 7'd64;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_valid && cfg_index == {1'b0, pfde_pkg::REG_WIDTH}) begin
                dw_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == {1'b0, pfde_pkg::REG_HEIGHT}) begin
                dh_reg <= cfg_data[6:0];
            end
            if (state_reg == pfde_pkg::ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= s_tuser;
            x0_reg    <= {s_tdata[11], s_tdata[11:0]};
            y0_reg    <= {s_tdata[23], s_tdata[23:12]};
            x1_reg    <= {s_tdata[35], s_tdata[35:24]};
            y1_reg    <= {s_tdata[47], s_tdata[47:36]};
            color_reg <= s_tdata[49:48];
            col_reg   <= s_tdata[57:50];
            page_reg  <= s_tdata[60:58];
        end
        if (state_reg == pfde_pkg::ST_TEST) begin
            addr_reg <= AW'(pix_addr);
            mask_reg <= 8'd1 << (cy_reg[2:0] & pfde_pkg::PIX_BIT_MASK);
        end
        if (state_reg == pfde_pkg::ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= res_reg;
        end
        kind_reg <= kind_next;
        seg_reg  <= seg_next;
        row_reg  <= row_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        lim_reg  <= lim_next;
        err_reg  <= err_next;
        dx2_reg  <= dx2_next;
        dy2_reg  <= dy2_next;
        neg_reg  <= neg_next;
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        res_reg  <= res_next;
    end

    pfde_fb_ram #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_tready  = (state_reg == pfde_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

`ifndef SYNTHESIS
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfde_pkg::ST_CLEAR) |-> !s_tready)
        else $error("command accepted during clearing pass");

    a_clear_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfde_pkg::ST_CLEAR && state_next != pfde_pkg::ST_CLEAR)
        |-> (clr_reg == AW'(DEPTH - 1)))
        else $error("clearing pass ended early");

    a_hrun_onscreen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfde_pkg::ST_TEST && kind_reg == pfde_pkg::KIND_H && go) |-> vis)
        else $error("clamped run left the screen");

    a_write_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfde_pkg::ST_WRITE) |=> (state_reg == pfde_pkg::ST_TEST))
        else $error("pixel write did not return to test");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command taken while busy");
`endif

endmodule
